// ===== hdl/assert_macros.svh =====
// Assertion macros used by the deque sequencer RTL (cdq_ctrl).
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
// Types and codes for the circular deque core.
// No dependencies; used by cdq_ram, cdq_ctrl and the top level.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DATA_W = 32;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_SEARCH     = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [2:0] STAT_FOUND     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] position;
    logic [6:0] count;
  } cdq_out_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic     valid;
    cdq_out_t word;
  } cdq_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP
  } state_t;

endpackage

// ===== hdl/cdq_ram.sv =====
// Element store of the deque: one write port, one registered read port.
// Depends on cdq_pkg for the data width.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [cdq_pkg::DATA_W-1:0] rd_data
);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/cdq_ctrl.sv =====
// Sequencer of the deque: ring pointers, push/pop updates and the search walk
// through one shared equality compare. Depends on cdq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  cdq_pkg::cdq_in_t           in_word,
  output logic                       in_stall,
  input  logic                       out_free,
  output cdq_pkg::cdq_res_t          res,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [cdq_pkg::DATA_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [cdq_pkg::DATA_W-1:0] rd_data
);

  localparam int SW = CW + 1;

  cdq_pkg::state_t            state_r, state_nxt;
  logic [AW-1:0]              front_r, front_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [cdq_pkg::DATA_W-1:0] key_r, key_nxt;

  logic [AW-1:0] front_dec, front_inc, addr_inc, back_addr;
  logic [SW-1:0] back_sum;
  logic          full, empty, hit, last, accept;

  assign front_dec = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + AW'(1);
  assign addr_inc  = (addr_r == AW'(CAPACITY - 1)) ? '0 : addr_r + AW'(1);
  // front + count stays below twice the capacity: one conditional subtract wraps it
  assign back_sum  = SW'(front_r) + SW'(cnt_r);
  assign back_addr = (back_sum >= SW'(CAPACITY)) ? AW'(back_sum - SW'(CAPACITY))
                                                 : AW'(back_sum);
  assign full   = (cnt_r == CW'(CAPACITY));
  assign empty  = (cnt_r == '0);
  assign hit    = (rd_data == key_r);
  assign last   = ((idx_r + CW'(1)) == cnt_r);
  assign accept = in_valid && out_free && (state_r == cdq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
      front_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    key_nxt   = key_r;
    in_stall  = !((state_r == cdq_pkg::ST_IDLE) && out_free);
    res.valid         = 1'b0;
    res.word.status   = cdq_pkg::STAT_OK;
    res.word.position = '0;
    wr_en   = 1'b0;
    wr_addr = front_dec;
    wr_data = in_word.value;
    rd_en   = 1'b0;
    rd_addr = addr_r;

    case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (accept) begin
          res.valid = 1'b1;
          case (in_word.kind)
            cdq_pkg::KIND_PUSH_FRONT: begin
              if (full) begin
                res.word.status = cdq_pkg::STAT_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            cdq_pkg::KIND_PUSH_BACK: begin
              if (full) begin
                res.word.status = cdq_pkg::STAT_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_addr;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            cdq_pkg::KIND_POP_FRONT: begin
              if (empty) begin
                res.word.status = cdq_pkg::STAT_UNDERFLOW;
              end else begin
                front_nxt = front_inc;
                cnt_nxt   = cnt_r - CW'(1);
              end
            end
            cdq_pkg::KIND_POP_BACK: begin
              if (empty) begin
                res.word.status = cdq_pkg::STAT_UNDERFLOW;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            cdq_pkg::KIND_SEARCH: begin
              if (empty) begin
                res.word.status = cdq_pkg::STAT_NOT_FOUND;
              end else begin
                // hold the result until the walk ends
                res.valid = 1'b0;
                state_nxt = cdq_pkg::ST_SRCH_RD;
                idx_nxt   = '0;
                addr_nxt  = front_r;
                key_nxt   = in_word.value;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cdq_pkg::ST_SRCH_RD: begin
        rd_en     = 1'b1;
        state_nxt = cdq_pkg::ST_SRCH_CMP;
      end
      cdq_pkg::ST_SRCH_CMP: begin
        if (hit || last) begin
          // read data holds while the output slot is busy
          if (out_free) begin
            res.valid = 1'b1;
            state_nxt = cdq_pkg::ST_IDLE;
            if (hit) begin
              res.word.status   = cdq_pkg::STAT_FOUND;
              res.word.position = 7'(idx_r + CW'(1));
            end else begin
              res.word.status = cdq_pkg::STAT_NOT_FOUND;
            end
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          addr_nxt  = addr_inc;
          state_nxt = cdq_pkg::ST_SRCH_RD;
        end
      end
      default: begin
        state_nxt = cdq_pkg::ST_IDLE;
      end
    endcase

    res.word.count = 7'(cnt_nxt);
  end

  `CDQ_ASSERT(a_cnt_bound, cnt_r <= CW'(CAPACITY), "element count above capacity")
  `CDQ_ASSERT(a_walk_idx, (state_r != cdq_pkg::ST_IDLE) |-> (idx_r < cnt_r), "walk past last element")
  `CDQ_ASSERT(a_walk_cnt, (state_r != cdq_pkg::ST_IDLE) |=> $stable(cnt_r), "count moved during search")
  `CDQ_ASSERT(a_ptr_range, (front_r <= AW'(CAPACITY - 1)) && (addr_r <= AW'(CAPACITY - 1)), "ring pointer out of range")

endmodule

// ===== hdl/circular_deque_with_search_core.sv =====
// Circular deque core with linear search: top level with the output register.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words kept in a ring of CAPACITY
// entries. For push front/back and pop front/back the word is accepted and its
// result is loaded into the output register at the same edge. A search walks
// the stored entries from the front through one shared compare, each entry in
// a registered memory read state and then a compare state, and reports the
// 1-based position of the first match; a search on an empty queue reports
// NOT_FOUND without a walk. The input stalls while a search runs and while a
// finished result waits in the output register with out_stall high. Position
// and count are reported modulo 128.

module circular_deque_with_search_core #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cdq_pkg::cdq_in_t  in_word,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::cdq_out_t out_word
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  cdq_pkg::cdq_res_t          res;
  logic                       out_free;
  logic                       out_valid_r;
  cdq_pkg::cdq_out_t          out_word_r;
  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [cdq_pkg::DATA_W-1:0] wr_data, rd_data;

  assign out_free = !out_valid_r || !out_stall;

  cdq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .out_free (out_free),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  cdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // drop the word once taken
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
